@@ sv/orbit_camera_view_matrix_top_defines.svh @@
// Assertion macros shared by the orbit camera view matrix RTL.
`ifndef ORBIT_CAMERA_VIEW_MATRIX_TOP_DEFINES_SVH
`define ORBIT_CAMERA_VIEW_MATRIX_TOP_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define OCV_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define OCV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ocvm_pkg.sv @@
// Shared types and constants for the orbit camera view matrix block.
`default_nettype none
package ocvm_pkg;

    localparam logic [1:0] FUNC_ORBIT = 2'd0;
    localparam logic [1:0] FUNC_PAN   = 2'd1;
    localparam logic [1:0] FUNC_DOLLY = 2'd2;
    localparam logic [1:0] FUNC_RESET = 2'd3;

    localparam logic [1:0] CFG_PITCH_FLOOR = 2'd0;
    localparam logic [1:0] CFG_PITCH_CEIL  = 2'd1;
    localparam logic [1:0] CFG_DIST_FLOOR  = 2'd2;
    localparam logic [1:0] CFG_DIST_CEIL   = 2'd3;

    localparam int ANG_PI      = 25736;
    localparam int ANG_TWO_PI  = 51472;
    localparam int ANG_HALF_PI = 12868;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
    localparam logic signed [31:0] RANGE_RESET = 32'sd196608;

    localparam logic signed [14:0] PITCH_FLOOR_RESET = -15'sd12698;
    localparam logic signed [14:0] PITCH_CEIL_RESET  = 15'sd12698;
    localparam logic [30:0] DIST_FLOOR_RESET = 31'd6554;
    localparam logic [30:0] DIST_CEIL_RESET  = 31'd65536000;

    // Arctangent table in Q2.30.
    function automatic logic signed [33:0] atan_lookup(input logic [3:0] i);
        logic signed [33:0] r;
        case (i)
            4'd0:  r = 34'sd843314857;
            4'd1:  r = 34'sd497837830;
            4'd2:  r = 34'sd263043837;
            4'd3:  r = 34'sd133525159;
            4'd4:  r = 34'sd67021687;
            4'd5:  r = 34'sd33543516;
            4'd6:  r = 34'sd16775851;
            4'd7:  r = 34'sd8388437;
            4'd8:  r = 34'sd4194283;
            4'd9:  r = 34'sd2097149;
            4'd10: r = 34'sd1048576;
            4'd11: r = 34'sd524288;
            4'd12: r = 34'sd262144;
            4'd13: r = 34'sd131072;
            4'd14: r = 34'sd65536;
            default: r = 34'sd32768;
        endcase
        return r;
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_CORDIC,
        ST_ROT,
        ST_PAN,
        ST_TRANS,
        ST_OUT
    } ctrl_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       load;       // capture the input word
        logic       update;     // apply orbit, dolly or state reset
        logic       cordic_init;
        logic       cordic_step;
        logic       rot_step;
        logic       pan_step;
        logic       trans_step;
        logic       out_load;
    } ctrl_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic cordic_done;
        logic rot_done;
        logic pan_done;
        logic trans_done;
        logic is_pan;
    } dp_status_t;

endpackage
`default_nettype wire

@@ sv/ocvm_ctrl.sv @@
// Sequencing state machine for the orbit camera view matrix block.
`default_nettype none
module ocvm_ctrl
    import ocvm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       out_busy,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);
    `include "orbit_camera_view_matrix_top_defines.svh"

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_CORDIC;
            ST_CORDIC: if (status.cordic_done) state_next = ST_ROT;
            ST_ROT:    if (status.rot_done) begin
                state_next = status.is_pan ? ST_PAN : ST_TRANS;
            end
            ST_PAN:    if (status.pan_done) state_next = ST_TRANS;
            ST_TRANS:  if (status.trans_done) state_next = ST_OUT;
            ST_OUT:    if (!out_busy) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                cmd.cordic_init = 1'b1;
            end
            ST_CORDIC: cmd.cordic_step = 1'b1;
            ST_ROT:    cmd.rot_step = 1'b1;
            ST_PAN:    cmd.pan_step = 1'b1;
            ST_TRANS:  cmd.trans_step = 1'b1;
            ST_OUT:    cmd.out_load = !out_busy;
            default:   cmd = '0;
        endcase
    end

    `OCV_ASSERT_IMP(a_ready_idle, aclk, aresetn, in_ready, state_reg == ST_IDLE, "ready outside idle")
    `OCV_ASSERT_NEXT(a_load_next, aclk, aresetn, cmd.load, state_reg == ST_UPDATE, "load not followed by update")
    `OCV_ASSERT_NEXT(a_out_idle, aclk, aresetn, cmd.out_load, state_reg == ST_IDLE, "output load not followed by idle")

endmodule
`default_nettype wire

@@ sv/ocvm_datapath.sv @@
// Datapath: camera state, shared CORDIC, shared multiplier, result register.
`default_nettype none
module ocvm_datapath
    import ocvm_pkg::*;
#(
    parameter int CORDIC_STEPS = 14
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ctrl_cmd_t          cmd,
    output dp_status_t              status,
    input  wire logic [1:0]         in_func,
    input  wire logic signed [15:0] in_yaw_delta,
    input  wire logic signed [15:0] in_pitch_delta,
    input  wire logic signed [31:0] in_pan_x,
    input  wire logic signed [31:0] in_pan_y,
    input  wire logic signed [31:0] in_dolly_step,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [30:0]        cfg_data,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic [239:0]            out_data
);
    localparam int SW = $clog2(CORDIC_STEPS + 1);

    // Configuration registers.
    logic signed [14:0] pitch_floor_reg, pitch_ceil_reg;
    logic [30:0] dist_floor_reg, dist_ceil_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_floor_reg <= PITCH_FLOOR_RESET;
            pitch_ceil_reg  <= PITCH_CEIL_RESET;
            dist_floor_reg  <= DIST_FLOOR_RESET;
            dist_ceil_reg   <= DIST_CEIL_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PITCH_FLOOR: pitch_floor_reg <= cfg_data[14:0];
                CFG_PITCH_CEIL:  pitch_ceil_reg  <= cfg_data[14:0];
                CFG_DIST_FLOOR:  dist_floor_reg  <= cfg_data;
                CFG_DIST_CEIL:   dist_ceil_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Captured input word.
    logic [1:0] func_reg;
    logic signed [15:0] yawd_reg, pitchd_reg;
    logic signed [31:0] panx_reg, pany_reg, dolly_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg   <= in_func;
            yawd_reg   <= in_yaw_delta;
            pitchd_reg <= in_pitch_delta;
            panx_reg   <= in_pan_x;
            pany_reg   <= in_pan_y;
            dolly_reg  <= in_dolly_step;
        end
    end

    // Camera state.
    logic signed [31:0] fx_reg, fy_reg, fz_reg, range_reg;
    logic signed [15:0] head_reg, elev_reg;

    logic signed [17:0] h_sum, h_wrap;
    logic signed [17:0] e_sum, e_clamp;
    logic signed [33:0] d_sum, d_clamp;

    always_comb begin
        h_sum = 18'(head_reg) + 18'(yawd_reg);
        if (h_sum >= 18'(ANG_PI)) h_wrap = h_sum - 18'(ANG_TWO_PI);
        else if (h_sum < -18'(ANG_PI)) h_wrap = h_sum + 18'(ANG_TWO_PI);
        else h_wrap = h_sum;
        e_sum = 18'(elev_reg) + 18'(pitchd_reg);
        e_clamp = e_sum;
        if (e_clamp < 18'(pitch_floor_reg)) e_clamp = 18'(pitch_floor_reg);
        if (e_clamp > 18'(pitch_ceil_reg)) e_clamp = 18'(pitch_ceil_reg);
        d_sum = 34'(range_reg) - 34'(dolly_reg);
        d_clamp = d_sum;
        if (d_clamp < $signed({3'b000, dist_floor_reg})) d_clamp = {3'b000, dist_floor_reg};
        if (d_clamp > $signed({3'b000, dist_ceil_reg})) d_clamp = {3'b000, dist_ceil_reg};
    end

    // Shared CORDIC: both angles rotated side by side over the step count.
    logic signed [33:0] cx_reg [2], cy_reg [2], cz_reg [2];
    logic neg_reg [2];
    logic [SW-1:0] step_reg;
    logic signed [15:0] ang [2];
    logic signed [15:0] sin_q [2], cos_q [2];

    assign ang[0] = cmd.update ? (func_reg == FUNC_ORBIT ? h_wrap[15:0] :
                                   func_reg == FUNC_RESET ? 16'sd0 : head_reg) : head_reg;
    assign ang[1] = cmd.update ? (func_reg == FUNC_ORBIT ? e_clamp[15:0] :
                                   func_reg == FUNC_RESET ? 16'sd0 : elev_reg) : elev_reg;

    function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
        logic signed [34:0] r;
        r = (35'(v) + 35'sd32768) >>> 16;
        if (r > 35'sd16384) r = 35'sd16384;
        if (r < -35'sd16384) r = -35'sd16384;
        return r[15:0];
    endfunction

    for (genvar g = 0; g < 2; g++) begin : g_cordic
        logic signed [15:0] a_fold;
        logic               a_neg;
        logic signed [33:0] dx, dy, at;
        always_comb begin
            a_neg = 1'b0;
            a_fold = ang[g];
            if (ang[g] > 16'(ANG_HALF_PI)) begin
                a_fold = ang[g] - 16'(ANG_PI); a_neg = 1'b1;
            end else if (ang[g] < -16'(ANG_HALF_PI)) begin
                a_fold = ang[g] + 16'(ANG_PI); a_neg = 1'b1;
            end
            dx = cy_reg[g] >>> step_reg;
            dy = cx_reg[g] >>> step_reg;
            at = atan_lookup(step_reg[3:0]);
        end
        always_ff @(posedge aclk) begin
            if (cmd.cordic_init) begin
                cx_reg[g]  <= CORDIC_GAIN;
                cy_reg[g]  <= '0;
                cz_reg[g]  <= 34'(a_fold) <<< 17;
                neg_reg[g] <= a_neg;
            end else if (cmd.cordic_step && step_reg < SW'(CORDIC_STEPS)) begin
                if (!cz_reg[g][33]) begin
                    cx_reg[g] <= cx_reg[g] - dx;
                    cy_reg[g] <= cy_reg[g] + dy;
                    cz_reg[g] <= cz_reg[g] - at;
                end else begin
                    cx_reg[g] <= cx_reg[g] + dx;
                    cy_reg[g] <= cy_reg[g] - dy;
                    cz_reg[g] <= cz_reg[g] + at;
                end
            end
        end
        assign sin_q[g] = to_q14(neg_reg[g] ? -cy_reg[g] : cy_reg[g]);
        assign cos_q[g] = to_q14(neg_reg[g] ? -cx_reg[g] : cx_reg[g]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) step_reg <= '0;
        else if (cmd.cordic_init) step_reg <= '0;
        else if (cmd.cordic_step && step_reg < SW'(CORDIC_STEPS)) step_reg <= step_reg + 1'b1;
    end
    assign status.cordic_done = (step_reg == SW'(CORDIC_STEPS));

    // Matrix entries; four products through one shared multiplier.
    logic signed [15:0] m_reg [9];
    logic [3:0] seq_reg;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic signed [63:0] acc_reg;
    logic signed [63:0] rnd14;
    assign rnd14 = (acc_reg + 64'sd8192) >>> 14;

    // Matrix entry picked for the pan and translation products.
    logic [3:0] right_idx, up_idx, row_base, trans_idx;
    logic [1:0] trans_col;
    always_comb begin
        right_idx = {1'b0, seq_reg[3:1]};
        up_idx = right_idx + 4'd3;
        case (seq_reg[3:2])
            2'd0: row_base = 4'd0;
            2'd1: row_base = 4'd3;
            default: row_base = 4'd6;
        endcase
        trans_col = (seq_reg[1:0] == 2'd3) ? 2'd2 : seq_reg[1:0];
        trans_idx = row_base + {2'b00, trans_col};
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.rot_step) begin
            case (seq_reg[1:0])
                2'd0: begin mul_a = 32'(sin_q[0]); mul_b = 32'(sin_q[1]); end
                2'd1: begin mul_a = 32'(cos_q[0]); mul_b = 32'(sin_q[1]); end
                2'd2: begin mul_a = 32'(sin_q[0]); mul_b = 32'(cos_q[1]); end
                default: begin mul_a = 32'(cos_q[0]); mul_b = 32'(cos_q[1]); end
            endcase
        end else if (cmd.pan_step) begin
            // Pairs (-px, right[k]) then (py, up[k]) per axis.
            case (seq_reg[0])
                1'b0: begin mul_a = panx_reg; mul_b = -32'(m_reg[right_idx]); end
                default: begin mul_a = pany_reg; mul_b = 32'(m_reg[up_idx]); end
            endcase
        end else if (cmd.trans_step) begin
            mul_b = 32'(m_reg[trans_idx]);
            case (seq_reg[1:0])
                2'd0: mul_a = fx_reg;
                2'd1: mul_a = fy_reg;
                default: mul_a = fz_reg;
            endcase
        end
    end

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    logic signed [31:0] t_reg [3];

    logic signed [15:0] rot_val;
    assign rot_val = rnd14[15:0];

    // Sequence counter shared by the multiply phases.
    logic seq_last;
    assign seq_last = cmd.rot_step ? (seq_reg == 4'd4) :
                      cmd.pan_step ? (seq_reg == 4'd6) :
                      (seq_reg[3:2] == 2'd3);
    assign status.rot_done   = cmd.rot_step && seq_last;
    assign status.pan_done   = cmd.pan_step && seq_last;
    assign status.trans_done = cmd.trans_step && seq_last;
    assign status.is_pan     = (func_reg == FUNC_PAN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg <= '0;
        end else if (cmd.rot_step || cmd.pan_step || cmd.trans_step) begin
            if (seq_last) seq_reg <= '0;
            else if (cmd.trans_step && seq_reg[1:0] == 2'd3) seq_reg <= seq_reg + 4'd1;
            else seq_reg <= seq_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rot_step) begin
            // Product of this cycle lands in acc, rounded next cycle.
            acc_reg <= mul_p;
            if (seq_reg == 4'd0) begin
                m_reg[0] <= cos_q[0];
                m_reg[1] <= '0;
                m_reg[2] <= -sin_q[0];
                m_reg[4] <= cos_q[1];
                m_reg[7] <= -sin_q[1];
            end
            case (seq_reg)
                4'd1: m_reg[3] <= rot_val;
                4'd2: m_reg[5] <= rot_val;
                4'd3: m_reg[6] <= rot_val;
                4'd4: m_reg[8] <= rot_val;
                default: ;
            endcase
        end else if (cmd.pan_step) begin
            // Even cycle: first product; odd: sum; register after each multiply.
            if (seq_reg == 4'd6) begin
                acc_reg <= '0;
            end else if (!seq_reg[0]) begin
                acc_reg <= mul_p;
            end else begin
                acc_reg <= acc_reg + mul_p;
            end
        end else if (cmd.trans_step) begin
            // Three products per row, fourth slot finalizes the row.
            case (seq_reg[1:0])
                2'd0: acc_reg <= mul_p;
                2'd3: begin
                    acc_reg <= '0;
                    if (seq_reg[3:2] == 2'd2)
                        t_reg[2] <= sat32(-rnd14 - 64'(range_reg));
                    else
                        t_reg[seq_reg[3:2]] <= sat32(-rnd14);
                end
                default: acc_reg <= acc_reg + mul_p;
            endcase
        end
    end

    // State update; also reset and register loads.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            elev_reg  <= '0;
            range_reg <= RANGE_RESET;
        end else if (cmd.update) begin
            case (func_reg)
                FUNC_ORBIT: begin
                    head_reg <= h_wrap[15:0];
                    elev_reg <= e_clamp[15:0];
                end
                FUNC_DOLLY: range_reg <= d_clamp[31:0];
                FUNC_RESET: begin
                    head_reg  <= '0;
                    elev_reg  <= '0;
                    range_reg <= RANGE_RESET;
                end
                default: ;
            endcase
        end
    end

    logic focus_clear;
    assign focus_clear = !aresetn || (cmd.update && func_reg == FUNC_RESET);

    // Output register.
    logic out_valid_reg;
    logic [239:0] out_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else if (cmd.out_load) out_valid_reg <= 1'b1;
        else if (out_ready) out_valid_reg <= 1'b0;
    end
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {t_reg[2], t_reg[1], t_reg[0],
                             m_reg[8], m_reg[7], m_reg[6], m_reg[5], m_reg[4],
                             m_reg[3], m_reg[2], m_reg[1], m_reg[0]};
        end
    end
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Focus point: cleared by reset or a state reset command, moved by a pan.
    // A pan finishes one axis on each even step after the first.
    always_ff @(posedge aclk) begin
        if (focus_clear) begin
            fx_reg <= '0;
            fy_reg <= '0;
            fz_reg <= '0;
        end else if (cmd.pan_step && !seq_reg[0] && seq_reg != 4'd0) begin
            case (seq_reg[3:1])
                3'd1: fx_reg <= sat32(64'(fx_reg) + rnd14);
                3'd2: fy_reg <= sat32(64'(fy_reg) + rnd14);
                default: fz_reg <= sat32(64'(fz_reg) + rnd14);
            endcase
        end
    end

endmodule
`default_nettype wire

@@ sv/orbit_camera_view_matrix_top.sv @@
// Orbit camera view matrix: top level joining controller and datapath.
//
// Input stream carries one command word: func picks orbit, pan, dolly or a
// state reset. The block updates its camera state and returns one word with
// the 3x3 rotation (Q2.14) and the translation (Q16.16) of the view matrix.
// From acceptance, a command passes the update, CORDIC, rotation, pan (for a
// pan only), translation and output states before m_axis_tvalid rises. One
// command is in work at a time, so a new word is taken only once the last
// result is in the output register; the CORDIC iterations and the single
// shared multiplier set the pace. s_axis_tready is high only while the
// block waits. Reset restores the camera state (focus at origin, range 3.0)
// and the pitch and distance limits. A stalled result stays in the output
// register; the controller holds the next result until it drains.
// Configuration writes take effect at once and should come while idle.
`default_nettype none
module orbit_camera_view_matrix_top
    import ocvm_pkg::*;
#(
    parameter int CORDIC_STEPS = 14
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // func, yaw_delta, pitch_delta, pan_x, pan_y, dolly_step from bit 0 up
    input  wire logic [135:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // m00..m22 then tx, ty, tz from bit 0 up
    output logic [239:0]      m_axis_tdata,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [30:0]  cfg_data
);
    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic unused_pad;
    assign unused_pad = ^s_axis_tdata[135:130];

    ocvm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_busy (m_axis_tvalid && !m_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ocvm_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .in_func        (s_axis_tdata[1:0]),
        .in_yaw_delta   (s_axis_tdata[17:2]),
        .in_pitch_delta (s_axis_tdata[33:18]),
        .in_pan_x       (s_axis_tdata[65:34]),
        .in_pan_y       (s_axis_tdata[97:66]),
        .in_dolly_step  (s_axis_tdata[129:98]),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_data       (m_axis_tdata)
    );

endmodule
`default_nettype wire
